// ===== rtl/btpc_pkg.sv =====
// Shared types and constants of the barometric compensation core.
`timescale 1ns / 1ps
`default_nettype none

package btpc_pkg;

    // Register index map of the configuration channel
    typedef enum logic [1:0] {
        CFG_TEMP    = 2'd0,
        CFG_PRESS_A = 2'd1,
        CFG_PRESS_B = 2'd2,
        CFG_PRESS_C = 2'd3
    } t_cfg_idx;

    localparam int TFINE_OFFSET = 128000;
    localparam int P_RAW_FULL   = 1048576;
    localparam int P_SCALE      = 3125;
    localparam int P4_SHIFT     = 35;
    localparam int TEMP_ROUND   = 128;

    // Temperature result fits 19 signed bits for every raw input and calibration
    localparam int TEMP_W    = 19;
    // Divisor magnitude is at most 2^30
    localparam int DIV_W     = 31;
    localparam int DIV_STEPS = 64;
    // Register stages from request to result strobe
    localparam int LATENCY   = 12 + DIV_STEPS + 7;

    // One stage of the restoring divider, with the payload that rides along
    typedef struct packed {
        logic              vld;
        logic              neg;
        logic              ok;
        logic [TEMP_W-1:0] temp;
        logic [DIV_W-1:0]  mb;
        logic [DIV_W-1:0]  rem;
        logic [63:0]       qd;
    } t_div_stage;

endpackage

`default_nettype wire

// ===== rtl/btpc_div.sv =====
// Pipelined 64-bit by 31-bit unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module btpc_div (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  btpc_pkg::t_div_stage  i_stage,
    output btpc_pkg::t_div_stage  o_stage
);

    btpc_pkg::t_div_stage r_stg [0:btpc_pkg::DIV_STEPS-1];

    for (genvar k = 0; k < btpc_pkg::DIV_STEPS; k++) begin : g_step
        btpc_pkg::t_div_stage      w_prev;
        btpc_pkg::t_div_stage      n_stg;
        logic [btpc_pkg::DIV_W:0]  w_shift;

        if (k == 0) begin : g_first
            assign w_prev = i_stage;
        end else begin : g_next
            assign w_prev = r_stg[k-1];
        end

        // Shift in the next dividend bit, subtract the divisor when it fits
        always_comb begin
            n_stg   = w_prev;
            w_shift = {w_prev.rem, w_prev.qd[63]};
            n_stg.qd = {w_prev.qd[62:0], 1'b0};
            if (w_shift >= {1'b0, w_prev.mb}) begin
                n_stg.rem   = btpc_pkg::DIV_W'(w_shift - {1'b0, w_prev.mb});
                n_stg.qd[0] = 1'b1;
            end else begin
                n_stg.rem = w_shift[btpc_pkg::DIV_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg[k].vld <= 1'b0;
            end else begin
                r_stg[k] <= n_stg;
            end
        end
    end

    assign o_stage = r_stg[btpc_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/baro_temp_press_compensation_core.sv =====
// Top level of the barometric temperature and pressure compensation core.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Pulse start with the six raw burst bytes of one reading on the i_press_*
//   and i_temp_* ports. busy stays low, so a request is taken in every cycle
//   that start is high; one reading per clock is sustained.
//   Each request yields one result: o_done is high for one
//   cycle with o_temperature_centi, o_pressure_q24_8 and o_pressure_valid.
//   The result passes the 64-stage restoring divider (one quotient bit per
//   stage), with 12 stages of calibration arithmetic before it and 7 after it;
//   only the square of d in the back stages is split into 32x32 partial products.
//   The receiver cannot stall; results leave on a fixed schedule.
//   Calibration words are written on the i_cfg_* channel (always ready) and
//   must change only while no request is in flight.
//   A synchronous active-low reset clears the calibration words to zero and
//   drops every request in flight.

module baro_temp_press_compensation_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [7:0]  i_press_msb,
    input  wire  [7:0]  i_press_lsb,
    input  wire  [7:0]  i_press_xlsb,
    input  wire  [7:0]  i_temp_msb,
    input  wire  [7:0]  i_temp_lsb,
    input  wire  [7:0]  i_temp_xlsb,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    output logic        o_done,
    output logic signed [31:0] o_temperature_centi,
    output logic [31:0] o_pressure_q24_8,
    output logic        o_pressure_valid
);

    localparam int TW = btpc_pkg::TEMP_W;
    localparam int DW = btpc_pkg::DIV_W;

    // Calibration registers
    logic [47:0] r_cal_t;
    logic [63:0] r_cal_pa;
    logic [63:0] r_cal_pb;
    logic [15:0] r_cal_pc;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t  <= '0;
            r_cal_pa <= '0;
            r_cal_pb <= '0;
            r_cal_pc <= '0;
        end else if (i_cfg_valid) begin
            unique case (btpc_pkg::t_cfg_idx'(i_cfg_index))
                btpc_pkg::CFG_TEMP:    r_cal_t  <= i_cfg_data[47:0];
                btpc_pkg::CFG_PRESS_A: r_cal_pa <= i_cfg_data;
                btpc_pkg::CFG_PRESS_B: r_cal_pb <= i_cfg_data;
                btpc_pkg::CFG_PRESS_C: r_cal_pc <= i_cfg_data[15:0];
                default:               r_cal_pc <= r_cal_pc;
            endcase
        end
    end

    // Coefficient fields
    logic [15:0]        w_t1, w_p1;
    logic signed [15:0] w_t2, w_t3, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;

    assign w_t1 = r_cal_t[15:0];
    assign w_t2 = $signed(r_cal_t[31:16]);
    assign w_t3 = $signed(r_cal_t[47:32]);
    assign w_p1 = r_cal_pa[15:0];
    assign w_p2 = $signed(r_cal_pa[31:16]);
    assign w_p3 = $signed(r_cal_pa[47:32]);
    assign w_p4 = $signed(r_cal_pa[63:48]);
    assign w_p5 = $signed(r_cal_pb[15:0]);
    assign w_p6 = $signed(r_cal_pb[31:16]);
    assign w_p7 = $signed(r_cal_pb[47:32]);
    assign w_p8 = $signed(r_cal_pb[63:48]);
    assign w_p9 = $signed(r_cal_pc);

    // Control and side payload that rides the front stages
    logic              r_vld  [1:12];
    logic [19:0]       r_adcp [1:9];
    logic [TW-1:0]     r_temp [5:12];

    // Front datapath registers
    logic signed [17:0] r1_ta;
    logic signed [16:0] r1_td;
    logic signed [33:0] r2_ma, r2_dd;
    logic signed [22:0] r3_a;
    logic signed [36:0] r3_bm;
    logic signed [23:0] r4_tf;
    logic signed [24:0] r5_pa;
    logic signed [49:0] r6_aa;
    logic signed [40:0] r6_ap5, r6_ap2, r7_ap5, r7_ap2;
    logic signed [63:0] r7_b6, r7_a3, r8_b, r8_a, r9_ap1, r9_b, r10_num0, r11_num;
    logic signed [DW-1:0] r10_div, r11_div;
    logic [63:0]        r12_ma;
    logic [DW-1:0]      r12_mb;
    logic               r12_neg, r12_ok;

    // Next values
    logic [19:0]        w_adct;
    logic signed [17:0] n1_ta;
    logic signed [16:0] n1_td;
    logic signed [33:0] n2_ma, n2_dd;
    logic signed [22:0] n3_a;
    logic signed [36:0] n3_bm;
    logic signed [23:0] n4_tf;
    logic signed [26:0] w_t5;
    logic signed [24:0] n5_pa;
    logic signed [49:0] n6_aa;
    logic signed [40:0] n6_ap5, n6_ap2;
    logic signed [63:0] n7_b6, n7_a3, n8_b, n8_a, n9_ap1, n10_num0, n11_num;
    logic signed [DW-1:0] n10_div;
    logic [20:0]        w_pr;

    // Temperature path, pressure prefactors and the divider numerator and divisor
    always_comb begin
        w_adct  = {i_temp_msb, i_temp_lsb, i_temp_xlsb[7:4]};
        n1_ta   = $signed({1'b0, w_adct[19:3]}) - $signed({1'b0, w_t1, 1'b0});
        n1_td   = $signed({1'b0, w_adct[19:4]}) - $signed({1'b0, w_t1});
        n2_ma   = 34'(r1_ta) * 34'(w_t2);
        n2_dd   = 34'(r1_td) * 34'(r1_td);
        n3_a    = $signed(r2_ma[33:11]);
        n3_bm   = 37'($signed(r2_dd[33:12])) * 37'(w_t3);
        n4_tf   = 24'(r3_a) + 24'($signed(r3_bm[36:14]));
        w_t5    = 27'(r4_tf) + (27'(r4_tf) <<< 2) + 27'(btpc_pkg::TEMP_ROUND);
        n5_pa   = 25'(r4_tf) - 25'(btpc_pkg::TFINE_OFFSET);
        n6_aa   = 50'(r5_pa) * 50'(r5_pa);
        n6_ap5  = 41'(r5_pa) * 41'(w_p5);
        n6_ap2  = 41'(r5_pa) * 41'(w_p2);
        n7_b6   = 64'(r6_aa) * 64'(w_p6);
        n7_a3   = 64'(r6_aa) * 64'(w_p3);
        n8_b    = r7_b6 + (64'(r7_ap5) <<< 17) + (64'(w_p4) <<< btpc_pkg::P4_SHIFT);
        n8_a    = (r7_a3 >>> 8) + (64'(r7_ap2) <<< 12) + (64'sd1 <<< 47);
        n9_ap1  = r8_a * 64'($signed({1'b0, w_p1}));
        n10_div = $signed(r9_ap1[63:33]);
        w_pr    = 21'(btpc_pkg::P_RAW_FULL) - {1'b0, r_adcp[9]};
        n10_num0 = $signed(64'(w_pr) << 31) - r9_b;
        n11_num = r10_num0 * 64'(btpc_pkg::P_SCALE);
    end

    // Advance the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 12; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[1] <= start && !busy;
            for (int k = 2; k <= 12; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_adcp[1] <= {i_press_msb, i_press_lsb, i_press_xlsb[7:4]};
        for (int k = 2; k <= 9; k++) begin
            r_adcp[k] <= r_adcp[k-1];
        end
        r_temp[5] <= w_t5[26:8];
        for (int k = 6; k <= 12; k++) begin
            r_temp[k] <= r_temp[k-1];
        end
        r1_ta    <= n1_ta;
        r1_td    <= n1_td;
        r2_ma    <= n2_ma;
        r2_dd    <= n2_dd;
        r3_a     <= n3_a;
        r3_bm    <= n3_bm;
        r4_tf    <= n4_tf;
        r5_pa    <= n5_pa;
        r6_aa    <= n6_aa;
        r6_ap5   <= n6_ap5;
        r6_ap2   <= n6_ap2;
        r7_b6    <= n7_b6;
        r7_a3    <= n7_a3;
        r7_ap5   <= r6_ap5;
        r7_ap2   <= r6_ap2;
        r8_b     <= n8_b;
        r8_a     <= n8_a;
        r9_ap1   <= n9_ap1;
        r9_b     <= r8_b;
        r10_div  <= n10_div;
        r10_num0 <= n10_num0;
        r11_div  <= r10_div;
        r11_num  <= n11_num;
        // Split signs from magnitudes for the divider
        r12_neg  <= r11_num[63] ^ r11_div[DW-1];
        r12_ok   <= (r11_div != '0);
        r12_ma   <= r11_num[63] ? (64'd0 - r11_num) : r11_num;
        r12_mb   <= r11_div[DW-1] ? (DW'(0) - r11_div) : r11_div;
    end

    // Divider
    btpc_pkg::t_div_stage w_din, w_dout;

    always_comb begin
        w_din.vld  = r_vld[12];
        w_din.neg  = r12_neg;
        w_din.ok   = r12_ok;
        w_din.temp = r_temp[12];
        w_din.mb   = r12_mb;
        w_din.rem  = '0;
        w_din.qd   = r12_ma;
    end

    btpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_din),
        .o_stage (w_dout)
    );

    // Back stages: p9, p8 and p7 corrections and saturation
    logic          r_pv   [1:6];
    logic          r_pok  [1:6];
    logic [TW-1:0] r_ptmp [1:6];

    logic signed [63:0] r1_p, r2_p, r3_p, r4_p, r2_pp8, r3_pp8, r4_pp8;
    logic signed [63:0] r3_dd, r4_t9, r5_s, r6_pf;
    logic [63:0]        r2_ll;
    logic [31:0]        r2_lh;

    logic signed [63:0] n1_p, w_d, n2_pp8, n3_dd, n4_t9, n5_s, n6_pf;
    logic [63:0]        n2_ll;
    logic [31:0]        n2_lh;
    logic [31:0]        n_press;

    always_comb begin
        n1_p   = w_dout.neg ? (64'sd0 - $signed(w_dout.qd)) : $signed(w_dout.qd);
        w_d    = r1_p >>> 13;
        // Square of d modulo 2^64 from two 32x32 partial products
        n2_ll  = 64'(w_d[31:0]) * 64'(w_d[31:0]);
        n2_lh  = 32'(w_d[31:0] * w_d[63:32]);
        n2_pp8 = r1_p * 64'(w_p8);
        n3_dd  = $signed(r2_ll + {r2_lh[30:0], 33'd0});
        n4_t9  = r3_dd * 64'(w_p9);
        n5_s   = r4_p + (r4_t9 >>> 25) + (r4_pp8 >>> 19);
        n6_pf  = (r5_s >>> 8) + (64'(w_p7) <<< 4);
        // Saturate to the unsigned 32-bit range; an invalid result gives zero
        if (!r_pok[6] || r6_pf[63]) begin
            n_press = '0;
        end else if (r6_pf[62:32] != '0) begin
            n_press = '1;
        end else begin
            n_press = r6_pf[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 6; k++) begin
                r_pv[k] <= 1'b0;
            end
            o_done <= 1'b0;
        end else begin
            r_pv[1] <= w_dout.vld;
            for (int k = 2; k <= 6; k++) begin
                r_pv[k] <= r_pv[k-1];
            end
            o_done <= r_pv[6];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pok[1]  <= w_dout.ok;
        r_ptmp[1] <= w_dout.temp;
        for (int k = 2; k <= 6; k++) begin
            r_pok[k]  <= r_pok[k-1];
            r_ptmp[k] <= r_ptmp[k-1];
        end
        r1_p   <= n1_p;
        r2_p   <= r1_p;
        r2_ll  <= n2_ll;
        r2_lh  <= n2_lh;
        r2_pp8 <= n2_pp8;
        r3_p   <= r2_p;
        r3_pp8 <= r2_pp8;
        r3_dd  <= n3_dd;
        r4_p   <= r3_p;
        r4_pp8 <= r3_pp8;
        r4_t9  <= n4_t9;
        r5_s   <= n5_s;
        r6_pf  <= n6_pf;
        o_temperature_centi <= 32'($signed(r_ptmp[6]));
        o_pressure_q24_8    <= n_press;
        o_pressure_valid    <= r_pok[6];
    end

    // Every request produces its result after the fixed pipeline latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(btpc_pkg::LATENCY) o_done)
        else $error("result strobe missing after request");

    // A zero divisor reports zero pressure
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_pressure_valid) |-> (o_pressure_q24_8 == '0))
        else $error("pressure not zero on invalid result");

    // Temperature stays inside its 19-bit signed range
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_temperature_centi[31:18] == '0) ||
                    (o_temperature_centi[31:18] == '1)))
        else $error("temperature outside expected range");

endmodule

`default_nettype wire
